// File: rtl/plst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional list store package
// Shared codes, default sizes and the control bundle sent to the list cells.
// ---------------------------------------------------------------------------
package plst_pkg;

    localparam int CAPACITY  = 32;
    localparam int WORD_BITS = 32;

    // Widest cell index for the largest supported capacity.
    localparam int MARK_BITS = 10;

    localparam int ACTION_BITS = 3;
    localparam int POS_BITS    = 6;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 6;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_INSERT  = 3'd0,
        ACT_REMOVE  = 3'd1,
        ACT_READ    = 3'd2,
        ACT_CLEAR   = 3'd3,
        ACT_REVERSE = 3'd4
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK     = 2'd0,
        STS_BADPOS = 2'd1,
        STS_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_REM  = 2'd2,
        SH_ROT  = 2'd3
    } t_shift;

    typedef struct packed {
        t_shift                op;
        logic [MARK_BITS-1:0]  mark;
    } t_cell_ctrl;

endpackage

// File: rtl/plst_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional list store channels
// Request and response channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface plst_req_if;
    logic                                valid;
    logic                                ready;
    logic [plst_pkg::ACTION_BITS-1:0]    action;
    logic [plst_pkg::POS_BITS-1:0]       position;
    logic signed [plst_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, action, position, value, input ready);
    modport sink   (input valid, action, position, value, output ready);
endinterface

interface plst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [plst_pkg::VALUE_BITS-1:0] data;
    logic [plst_pkg::STATUS_BITS-1:0]    status;
    logic [plst_pkg::COUNT_BITS-1:0]     count;

    modport source (output valid, data, status, count, input ready);
    modport sink   (input valid, data, status, count, output ready);
endinterface

// File: rtl/plst_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional list store cell
// One list entry; loads from a neighbor, the head entry or the new word.
// ---------------------------------------------------------------------------
module plst_cell #(
    parameter int WORD_BITS = plst_pkg::WORD_BITS,
    parameter int IDX       = 0
) (
    input  logic                   i_clk,
    input  plst_pkg::t_cell_ctrl   i_ctrl,
    input  logic [WORD_BITS-1:0]   i_left,
    input  logic [WORD_BITS-1:0]   i_right,
    input  logic [WORD_BITS-1:0]   i_head,
    input  logic [WORD_BITS-1:0]   i_word,
    output logic [WORD_BITS-1:0]   o_entry
);

    logic [WORD_BITS-1:0] r_entry;
    logic [WORD_BITS-1:0] n_entry;
    int                   mark;

    always_comb begin
        mark    = int'(i_ctrl.mark);
        n_entry = r_entry;
        case (i_ctrl.op)
            plst_pkg::SH_INS: begin
                if (IDX > mark) begin
                    n_entry = i_left;
                end else if (IDX == mark) begin
                    n_entry = i_word;
                end
            end
            plst_pkg::SH_REM: begin
                if (IDX >= mark) begin
                    n_entry = i_right;
                end
            end
            plst_pkg::SH_ROT: begin
                if (IDX < mark) begin
                    n_entry = i_right;
                end else if (IDX == mark) begin
                    n_entry = i_head;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// File: rtl/positional_list_store_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional list store
// Bounded ordered list held in a row of cells that shift in parallel.
// ---------------------------------------------------------------------------
// Latency: the response is registered and is presented in the cycle after the request transfer.
// Throughput: one request per cycle unless the response is held; a reverse of
// n entries keeps the request side closed while the cell row rotates step by step.
// Reset: the fill count, response valid and state clear together on a clock edge;
// entries are not cleared, since only entries below the fill count are ever read.
// ---------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY  = plst_pkg::CAPACITY,
    parameter int WORD_BITS = plst_pkg::WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    plst_req_if.sink         i_req,
    plst_rsp_if.source       o_rsp
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > plst_pkg::POS_BITS) ? FW : plst_pkg::POS_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_REV  = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [FW-1:0]          r_fill, n_fill;
    logic [FW-1:0]          r_limit, n_limit;
    logic                   r_valid;
    logic signed [plst_pkg::VALUE_BITS-1:0] r_data, n_data;
    plst_pkg::t_status      r_status, n_status;

    logic [WORD_BITS-1:0]   cell_q [CAPACITY];
    logic [WORD_BITS-1:0]   word;
    logic [WORD_BITS-1:0]   rd_word;
    logic [CW-1:0]          pos_c;
    logic [CW-1:0]          fill_c;
    logic                   accept;
    plst_pkg::t_cell_ctrl   ctrl;

    assign i_req.ready = (r_state == ST_IDLE) && (!r_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign pos_c       = CW'(i_req.position);
    assign fill_c      = CW'(r_fill);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            word[b] = (b < plst_pkg::VALUE_BITS) ? i_req.value[b] : 1'b0;
        end
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_c == CW'(i)) begin
                rd_word = cell_q[i];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_limit  = r_limit;
        n_data   = r_data;
        n_status = r_status;
        ctrl.op   = plst_pkg::SH_HOLD;
        ctrl.mark = plst_pkg::MARK_BITS'(i_req.position);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_data   = '0;
                    n_status = plst_pkg::STS_OK;
                    case (plst_pkg::t_action'(i_req.action))
                        plst_pkg::ACT_INSERT: begin
                            if (pos_c > fill_c) begin
                                n_status = plst_pkg::STS_BADPOS;
                            end else if (fill_c >= CW'(CAPACITY)) begin
                                n_status = plst_pkg::STS_FULL;
                            end else begin
                                ctrl.op = plst_pkg::SH_INS;
                                n_fill  = r_fill + FW'(1);
                            end
                        end
                        plst_pkg::ACT_REMOVE: begin
                            if (pos_c >= fill_c) begin
                                n_status = plst_pkg::STS_BADPOS;
                            end else begin
                                ctrl.op = plst_pkg::SH_REM;
                                n_fill  = r_fill - FW'(1);
                                for (int b = 0; b < plst_pkg::VALUE_BITS; b++) begin
                                    n_data[b] = (b < WORD_BITS) ? rd_word[b] : 1'b0;
                                end
                            end
                        end
                        plst_pkg::ACT_READ: begin
                            if (pos_c >= fill_c) begin
                                n_status = plst_pkg::STS_BADPOS;
                            end else begin
                                for (int b = 0; b < plst_pkg::VALUE_BITS; b++) begin
                                    n_data[b] = (b < WORD_BITS) ? rd_word[b] : 1'b0;
                                end
                            end
                        end
                        plst_pkg::ACT_CLEAR: begin
                            n_fill = '0;
                        end
                        plst_pkg::ACT_REVERSE: begin
                            if (r_fill > FW'(1)) begin
                                n_limit = r_fill - FW'(1);
                                n_state = ST_REV;
                            end
                        end
                        default: begin
                            n_status = plst_pkg::STS_OK;
                        end
                    endcase
                end
            end
            ST_REV: begin
                ctrl.op   = plst_pkg::SH_ROT;
                ctrl.mark = plst_pkg::MARK_BITS'(r_limit);
                n_limit   = r_limit - FW'(1);
                if (r_limit == FW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;
        if (g == 0) begin : g_first
            assign left = word;
        end else begin : g_mid_l
            assign left = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_q[g];
        end else begin : g_mid_r
            assign right = cell_q[g+1];
        end
        plst_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_left  (left),
            .i_right (right),
            .i_head  (cell_q[0]),
            .i_word  (word),
            .o_entry (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        if (accept) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid  = r_valid;
    assign o_rsp.data   = r_data;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = plst_pkg::COUNT_BITS'(r_fill);

    a_rev_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REV) |-> !i_req.ready)
        else $error("Request taken during reverse.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("Fill count above capacity.");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("Response missing after request transfer.");

    a_rev_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REV) |-> (r_limit != '0) && (r_limit < r_fill))
        else $error("Reverse step outside the stored run.");

endmodule
